// File: hdl/tmph_pkg.sv
// ----------------------------------------------------------------------------
// tmph_pkg
// Shared widths, scaling constants and types of the trimmed-mean pH converter.
// ----------------------------------------------------------------------------
package tmph_pkg;

   // converter sample, offset and result widths
   localparam int ADC_W    = 10;
   localparam int OFFSET_W = 16;
   localparam int PH_W     = 18;

   // pH scale: 35/2048 pH per count (5.0/1024 * 3.5)
   localparam int SCALE_W  = 6;
   localparam int PH_SCALE = 35;
   localparam int PROD_W   = ADC_W + SCALE_W;

   // scaled result handed from the mean/scale unit to the top level
   typedef struct packed {
      logic            valid;
      logic [PH_W-1:0] ph_value;
   } scale_rsp_type;

endpackage

// File: hdl/trimmed_mean_ph_converter_unit.sv
// ----------------------------------------------------------------------------
// trimmed_mean_ph_converter_unit
// Insertion-sorts each burst of samples into a RAM as they arrive, then sums
// the untrimmed middle entries, divides, scales to 1/2048 pH and adds offset.
// ----------------------------------------------------------------------------
// Per sample: one RAM shift a cycle while larger entries move up, then the
// sample is written into its slot; the sample after an insertion is taken at once.
// Last sample of a burst: insertion, then RAM readout of the kept entries,
// the divide, the scale multiply and offset add, the handoff and the output load.
// Throughput set by the shift loop through the single RAM port pair.
// Synchronous reset empties the burst and output register; offset resets to 0.
module trimmed_mean_ph_converter_unit #(
   parameter int SAMPLE_COUNT  = 10,
   parameter int TRIM_EACH_END = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [tmph_pkg::ADC_W-1:0]     req_adc_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [tmph_pkg::PH_W-1:0]      rsp_ph_value,
   input  logic                           csr_wr_en,
   input  logic [tmph_pkg::OFFSET_W-1:0]  csr_wr_data
);
   import tmph_pkg::*;

   localparam int  ADDR_W   = $clog2(SAMPLE_COUNT);
   localparam int  CNT_W    = $clog2(SAMPLE_COUNT + 1);
   localparam int  SUM_W    = ADC_W + $clog2(SAMPLE_COUNT + 1);
   localparam bit  HAS_KEPT = (SAMPLE_COUNT > 2 * TRIM_EACH_END);
   localparam int  DIVISOR  = HAS_KEPT ? SAMPLE_COUNT - 2 * TRIM_EACH_END : 1;
   localparam int  FIRST    = HAS_KEPT ? TRIM_EACH_END : 0;
   localparam int  LAST     = HAS_KEPT ? SAMPLE_COUNT - TRIM_EACH_END - 1 : 0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]   pos_ff, pos_in;
   logic [ADC_W-1:0]    sample_ff, sample_in;
   logic [ADDR_W-1:0]   sum_idx_ff, sum_idx_in;
   logic                sum_issue_ff, sum_issue_in;
   logic                data_vld_ff, data_vld_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [OFFSET_W-1:0] offset_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PH_W-1:0]     rsp_ph_ff, rsp_ph_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [ADC_W-1:0]    ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [ADC_W-1:0]    ram_rdata;
   logic                div_start;
   scale_rsp_type       scale_rsp;
   logic                placed;

   // sorted burst store
   tmph_ram #(
      .WIDTH (ADC_W),
      .DEPTH (SAMPLE_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // divide, scale and offset
   tmph_mean_scale #(
      .SUM_W   (SUM_W),
      .DIVISOR (DIVISOR)
   ) u_mean_scale (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .sum       (acc_ff),
      .ph_offset (offset_ff),
      .rsp       (scale_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      sample_in    = sample_ff;
      sum_idx_in   = sum_idx_ff;
      sum_issue_in = sum_issue_ff;
      data_vld_in  = data_vld_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ph_in    = rsp_ph_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = sample_ff;
      ram_raddr    = pos_ff - 1'b1;
      div_start    = 1'b0;
      placed       = 1'b0;

      // output register drains on a transfer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            ram_raddr = ADDR_W'(count_ff - 1'b1);
            if (req_valid) begin
               sample_in = req_adc_sample;
               pos_in    = count_ff[ADDR_W-1:0];
               state_in  = (count_ff == '0) ? ST_PLACE : ST_SHIFT;
            end
         end
         // move larger entries up one slot until the hole fits the sample
         ST_SHIFT: begin
            ram_we = 1'b1;
            if (ram_rdata > sample_ff) begin
               ram_wdata = ram_rdata;
               pos_in    = pos_ff - 1'b1;
               ram_raddr = pos_ff - ADDR_W'(2);
               if (pos_ff == ADDR_W'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               placed = 1'b1;
            end
         end
         ST_PLACE: begin
            ram_we = 1'b1;
            placed = 1'b1;
         end
         // read the untrimmed middle of the sorted burst and accumulate
         ST_SUM: begin
            ram_raddr   = sum_idx_ff;
            data_vld_in = sum_issue_ff;
            if (sum_issue_ff) begin
               if (sum_idx_ff == ADDR_W'(LAST)) begin
                  sum_issue_in = 1'b0;
               end else begin
                  sum_idx_in = sum_idx_ff + 1'b1;
               end
            end
            if (data_vld_ff) begin
               acc_in = acc_ff + SUM_W'(ram_rdata);
            end
            if (!sum_issue_ff && !data_vld_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (scale_rsp.valid) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ph_in    = scale_rsp.ph_value;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // sample written into its slot: burst grows, full burst goes to readout
      if (placed) begin
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(SAMPLE_COUNT - 1)) begin
            state_in     = ST_SUM;
            sum_idx_in   = ADDR_W'(FIRST);
            sum_issue_in = HAS_KEPT;
            data_vld_in  = 1'b0;
            acc_in       = '0;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         sum_issue_ff <= 1'b0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         offset_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_issue_ff <= sum_issue_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            offset_ff <= csr_wr_data;
         end
      end
      pos_ff     <= pos_in;
      sample_ff  <= sample_in;
      sum_idx_ff <= sum_idx_in;
      acc_ff     <= acc_in;
      rsp_ph_ff  <= rsp_ph_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ph_value = rsp_ph_ff;

endmodule

// File: hdl/tmph_ram.sv
// ----------------------------------------------------------------------------
// tmph_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmph_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/tmph_mean_scale.sv
// ----------------------------------------------------------------------------
// tmph_mean_scale
// Divides the trimmed sum by the kept-sample count with a reciprocal multiply,
// then scales the mean by 35 and adds the signed calibration offset.
// ----------------------------------------------------------------------------
module tmph_mean_scale #(
   parameter int SUM_W   = 14,
   parameter int DIVISOR = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [SUM_W-1:0]                sum,
   input  logic [tmph_pkg::OFFSET_W-1:0]   ph_offset,
   output tmph_pkg::scale_rsp_type         rsp
);
   import tmph_pkg::*;

   // floor(sum / DIVISOR) = (sum * RECIP) >> SHIFT, exact for any sum of SUM_W bits
   localparam int     LOG_D   = $clog2(DIVISOR);
   localparam int     SHIFT   = SUM_W + LOG_D;
   localparam int     RECIP_W = SUM_W + 1;
   localparam int     QPROD_W = SUM_W + RECIP_W;
   localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(DIVISOR - 1))
                              / longint'(DIVISOR);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_MUL,
      S_ADD
   } state_type;

   state_type          state_ff, state_in;
   logic [SUM_W-1:0]   dvd_ff, dvd_in;
   logic [ADC_W-1:0]   mean_ff, mean_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PH_W-1:0]    ph_ff, ph_in;
   logic               valid_ff, valid_in;
   logic [QPROD_W-1:0] quot_prod;

   // sum times the scaled reciprocal of the kept-sample count
   assign quot_prod = QPROD_W'(dvd_ff) * QPROD_W'(RECIP);

   always_comb begin
      state_in = state_ff;
      dvd_in   = dvd_ff;
      mean_in  = mean_ff;
      prod_in  = prod_ff;
      ph_in    = ph_ff;
      valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dvd_in   = sum;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // quotient stays below 1024: the mean of 10-bit samples
            mean_in  = ADC_W'(quot_prod >> SHIFT);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(mean_ff) * PROD_W'(PH_SCALE);
            state_in = S_ADD;
         end
         S_ADD: begin
            ph_in    = PH_W'(prod_ff)
                     + {{(PH_W-OFFSET_W){ph_offset[OFFSET_W-1]}}, ph_offset};
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      dvd_ff  <= dvd_in;
      mean_ff <= mean_in;
      prod_ff <= prod_in;
      ph_ff   <= ph_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.ph_value = ph_ff;

endmodule

// File: hdl/tmph_checker.sv
// ----------------------------------------------------------------------------
// tmph_checker
// Port-level checks of the trimmed-mean pH converter, bound to the top level.
// ----------------------------------------------------------------------------
module tmph_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [tmph_pkg::PH_W-1:0]   rsp_ph_value
);
   import tmph_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ph_value))
      else $error("stalled result changed");

   // reset leaves no result pending
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // every accepted sample stalls the request channel in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample taken without insertion cycle");

   // scaled mean plus offset stays at or below the top of the pH range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_ph_value) <= 18'sd68572))
      else $error("ph value out of range");

endmodule

bind trimmed_mean_ph_converter_unit tmph_checker u_tmph_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives bursts of converter samples into the trimmed-mean pH converter and
// checks every pH result against a local trimmed-mean and scale computation,
// under several offset settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   import tmph_pkg::*;

   localparam int SAMPLE_COUNT  = 10;
   localparam int TRIM_EACH_END = 2;
   localparam int ADC_MAX       = (1 << ADC_W) - 1;
   localparam int SETTLE_CYCLES = 128;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_BURSTS = 24;

   typedef enum int {
      STYLE_UNIFORM,
      STYLE_RAILS,
      STYLE_CLUSTER,
      STYLE_OUTLIER
   } burst_style_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [ADC_W-1:0]    req_adc_sample = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [PH_W-1:0]     rsp_ph_value;
   logic                csr_wr_en      = 1'b0;
   logic [OFFSET_W-1:0] csr_wr_data    = '0;

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;

   // local copy of the burst and the offset register
   logic [ADC_W-1:0]           burst_held [SAMPLE_COUNT];
   int                         burst_fill = 0;
   logic signed [OFFSET_W-1:0] offset_now = '0;
   logic [PH_W-1:0]            ph_expected [$];

   int error_count     = 0;
   int samples_sent    = 0;
   int results_checked = 0;
   int offsets_written = 0;
   int cycle_count     = 0;

   trimmed_mean_ph_converter_unit #(
      .SAMPLE_COUNT  (SAMPLE_COUNT),
      .TRIM_EACH_END (TRIM_EACH_END)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_adc_sample (req_adc_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ph_value   (rsp_ph_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // random receiver stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, ph_expected.size());
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // add one sample to the burst; a full burst yields one expected pH value
   task automatic absorb_sample(input logic [ADC_W-1:0] sample);
      logic [ADC_W-1:0] ordered [SAMPLE_COUNT];
      logic [ADC_W-1:0] key;
      int j;
      int kept;
      int sum;
      int mean;
      int scaled;
      burst_held[burst_fill] = sample;
      burst_fill++;
      if (burst_fill == SAMPLE_COUNT) begin
         burst_fill = 0;
         ordered = burst_held;
         // insertion sort, ascending
         for (int i = 1; i < SAMPLE_COUNT; i++) begin
            key = ordered[i];
            j = i - 1;
            while (j >= 0) begin
               if (ordered[j] <= key) break;
               ordered[j + 1] = ordered[j];
               j--;
            end
            ordered[j + 1] = key;
         end
         // mean of the untrimmed middle, zero when nothing is kept
         kept = SAMPLE_COUNT - 2 * TRIM_EACH_END;
         mean = 0;
         if (kept > 0) begin
            sum = 0;
            for (int i = TRIM_EACH_END; i < SAMPLE_COUNT - TRIM_EACH_END; i++)
               sum += ordered[i];
            mean = sum / kept;
         end
         scaled = mean * PH_SCALE + int'(offset_now);
         ph_expected.push_back(scaled[PH_W-1:0]);
      end
   endtask

   // one sample transfer on the request channel
   task automatic send_sample(input logic [ADC_W-1:0] sample);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_adc_sample <= sample;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      absorb_sample(sample);
      samples_sent++;
   endtask

   // wait until all results are out and any partial-burst work has finished
   task automatic settle_block();
      req_valid <= 1'b0;
      while (ph_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [OFFSET_W-1:0] value);
      settle_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      offset_now = value;
      offsets_written++;
   endtask

   function automatic logic [ADC_W-1:0] pick_sample(burst_style_type style, int center);
      int v;
      case (style)
         STYLE_RAILS: begin
            case ($urandom_range(0, 3))
               0:       v = 0;
               1:       v = ADC_MAX;
               2:       v = 'h2AA;
               default: v = 'h155;
            endcase
         end
         STYLE_CLUSTER: v = center + int'($urandom_range(0, 16)) - 8;
         STYLE_OUTLIER: begin
            if ($urandom_range(0, 4) == 0) v = $urandom_range(0, 1) ? ADC_MAX : 0;
            else v = center + int'($urandom_range(0, 6)) - 3;
         end
         default: v = $urandom_range(0, ADC_MAX);
      endcase
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
      return v[ADC_W-1:0];
   endfunction

   // full-scale burst with the largest offset gives the top of the range
   task automatic test_max_result();
      write_offset(16'h7FFF);
      repeat (SAMPLE_COUNT) send_sample(ADC_W'(ADC_MAX));
   endtask

   // two full-scale outliers are trimmed, mean 0 with the most negative offset
   task automatic test_min_result();
      write_offset(16'h8000);
      for (int i = 0; i < SAMPLE_COUNT; i++)
         send_sample((i == 0 || i == 4) ? ADC_W'(ADC_MAX) : '0);
   endtask

   // random bursts of mixed shapes, ending on a partial burst of zero to SAMPLE_COUNT-1 samples
   task automatic test_random_bursts(input logic [OFFSET_W-1:0] offset,
                                     input int send_pct, input int rsp_pct);
      burst_style_type style;
      int              center;
      int              extra;
      write_offset(offset);
      send_idle_pct = send_pct;
      rsp_idle_pct  = rsp_pct;
      repeat (RANDOM_BURSTS) begin
         style  = burst_style_type'($urandom_range(0, 3));
         center = $urandom_range(0, ADC_MAX);
         repeat (SAMPLE_COUNT) send_sample(pick_sample(style, center));
      end
      extra = $urandom_range(0, SAMPLE_COUNT - 1);
      repeat (extra) send_sample(ADC_W'($urandom_range(0, ADC_MAX)));
   endtask

   // compare each result transfer with the oldest expected pH value
   always @(posedge clock) begin
      logic [PH_W-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (ph_expected.size() == 0) begin
            report_mismatch($sformatf("unexpected ph_value %0d", $signed(rsp_ph_value)));
         end else begin
            want = ph_expected.pop_front();
            results_checked++;
            if (rsp_ph_value !== want)
               report_mismatch($sformatf("ph_value %0d, expected %0d",
                                         $signed(rsp_ph_value), $signed(want)));
         end
      end
   end

   // test sequence
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 12;
      rsp_idle_pct  = 66;
      test_max_result();
      test_min_result();
      test_random_bursts(16'h0000, 12, 66);
      test_random_bursts(OFFSET_W'($urandom), 12, 66);
      test_random_bursts(16'h8000, 66, 12);
      test_random_bursts(16'h7FFF, 66, 12);
      test_random_bursts(16'hFFFF, 0, 0);
      test_random_bursts(OFFSET_W'($urandom), 0, 0);
      settle_block();
      $display("checked %0d pH results from %0d samples over %0d offset settings",
               results_checked, samples_sent, offsets_written);
      $display("idling on either side and none, %0d mismatches", error_count);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
